/* design/assert_macros.svh */
// Assertion macros shared by the free list RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Check that a condition in one cycle implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/fbfl_pkg.sv */
// Package for the fixed block free list: item types, field widths and codes.
// Used by the top level; no dependencies of its own.
package fbfl_pkg;

    localparam int SIZE_W   = 13;
    localparam int INDEX_W  = 12;
    localparam int OFFSET_W = 15;
    localparam int STATUS_W = 2;

    // Block size limits and reset value
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd8;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 13'd4096;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd64;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] free_index;
    } t_req;

    typedef struct packed {
        logic [INDEX_W-1:0]  block_index;
        logic [OFFSET_W-1:0] block_offset;
        logic [STATUS_W-1:0] status;
    } t_rsp;

endpackage

/* design/fbfl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read data holds when no read is issued.
module fbfl_ram #(
    parameter  int WIDTH = 12,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* design/fixed_block_free_list_top.sv */
// Fixed block free list: top level, FIFO free ring in one RAM plus size divider.
// Depends on fbfl_pkg, fbfl_ram and assert_macros.svh.
//
// Allocates and frees equal-sized blocks of a PAGE_BYTES*PAGES byte pool. Each
// item (alloc or free) gives one result item via stage one and the output register,
// and a new item is taken every cycle while the output side does not stall;
// the single ring RAM is read once for an alloc and written once for a free.
// Writing block_size clamps it to 8..4096 and rebuilds the list: the block
// count is found by a restoring divider, one quotient bit per cycle, so input
// is stalled until the divider has produced its last quotient bit.
// There is no clearing pass: a write mark counts ring slots filled since the
// last rebuild, and a slot beyond the mark reads as its own position.
`include "assert_macros.svh"

module fixed_block_free_list_top #(
    parameter int PAGE_BYTES = 4096,
    parameter int PAGES      = 5,
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  fbfl_pkg::t_req              i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output fbfl_pkg::t_rsp              o_out_data,
    input  logic                        i_cfg_we,
    input  logic [fbfl_pkg::SIZE_W-1:0] i_cfg_wdata
);
    import fbfl_pkg::*;

    localparam int POOL    = PAGE_BYTES * PAGES;
    localparam int DVD_W   = $clog2(POOL);
    localparam int STEP_W  = $clog2(DVD_W);
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int PROD_W  = IDX_W + SIZE_W;
    localparam int RST_Q   = (POOL - 1) / SIZE_RESET;
    localparam int RST_CNT = (RST_Q > MAX_BLOCKS) ? MAX_BLOCKS : RST_Q;

    localparam logic [DVD_W-1:0]  DIVIDEND = DVD_W'(POOL - 1);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BLOCKS);
    localparam logic [SUM_W-1:0]  MAX_SUM  = SUM_W'(MAX_BLOCKS);
    localparam logic [IDX_W-1:0]  LAST_POS = IDX_W'(MAX_BLOCKS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } t_state;

    t_state              r_state;
    logic [SIZE_W-1:0]   r_eff_size;
    logic [CNT_W-1:0]    r_blk_cnt;
    logic [CNT_W-1:0]    r_free_cnt, n_free_cnt;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_wmark, n_wmark;
    logic [SIZE_W-1:0]   r_rem, n_rem;
    logic [DVD_W-1:0]    r_quo, n_quo;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    w_quo_cap;
    logic [SIZE_W-1:0]   w_cfg_size;

    logic                r_s1_valid;
    logic                r_s1_pop;
    logic                r_s1_hit;
    logic [IDX_W-1:0]    r_s1_pos;
    logic [STATUS_W-1:0] r_s1_status;
    logic                r_out_valid;
    t_rsp                r_out_data;

    logic                w_accept;
    logic                w_s1_move;
    logic                w_is_free;
    logic                w_pop_ok;
    logic                w_push_ok;
    logic [STATUS_W-1:0] w_status;
    logic [SUM_W-1:0]    w_tail_sum;
    logic [IDX_W-1:0]    w_tail_pos;
    logic [SUM_W-1:0]    w_head_dist;
    logic                w_head_hit;
    logic [SIZE_W:0]     w_rem_sh;
    logic [IDX_W-1:0]    w_ram_rdata;
    logic [IDX_W-1:0]    w_sel_index;
    logic [PROD_W-1:0]   w_prod;

    // Handshake: hold input while dividing or while stage one cannot drain
    assign w_s1_move  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != ST_RUN) || (r_s1_valid && !w_s1_move);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Clamp a written block size into the legal range
    always_comb begin
        if (i_cfg_wdata < SIZE_MIN) begin
            w_cfg_size = SIZE_MIN;
        end else if (i_cfg_wdata > SIZE_MAX) begin
            w_cfg_size = SIZE_MAX;
        end else begin
            w_cfg_size = i_cfg_wdata;
        end
    end

    // Restoring divider step: one quotient bit of (pool - 1) / size
    always_comb begin
        w_rem_sh = {r_rem, DIVIDEND[r_step]};
        if (w_rem_sh >= {1'b0, r_eff_size}) begin
            n_rem = SIZE_W'(w_rem_sh - {1'b0, r_eff_size});
            n_quo = {r_quo[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = w_rem_sh[SIZE_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b0};
        end
        if (32'(n_quo) > 32'(MAX_BLOCKS)) begin
            w_quo_cap = MAX_CNT;
        end else begin
            w_quo_cap = CNT_W'(n_quo);
        end
    end

    // Ring positions: tail slot and whether the head slot was written
    always_comb begin
        w_tail_sum = SUM_W'(r_head) + SUM_W'(r_free_cnt);
        if (w_tail_sum >= MAX_SUM) begin
            w_tail_pos = IDX_W'(w_tail_sum - MAX_SUM);
        end else begin
            w_tail_pos = IDX_W'(w_tail_sum);
        end
        if (SUM_W'(r_head) >= SUM_W'(r_blk_cnt)) begin
            w_head_dist = SUM_W'(r_head) - SUM_W'(r_blk_cnt);
        end else begin
            w_head_dist = SUM_W'(r_head) + MAX_SUM - SUM_W'(r_blk_cnt);
        end
        w_head_hit = w_head_dist < SUM_W'(r_wmark);
    end

    // Decode the item and pick its status
    always_comb begin
        w_is_free = (i_in_data.cmd == CMD_FREE);
        w_pop_ok  = !w_is_free && (r_free_cnt != '0);
        w_push_ok = w_is_free
                 && (32'(i_in_data.free_index) < 32'(r_blk_cnt))
                 && (r_free_cnt < r_blk_cnt);
        if (!w_is_free && !w_pop_ok) begin
            w_status = STATUS_EMPTY;
        end else if (w_is_free && !w_push_ok) begin
            w_status = STATUS_REJECT;
        end else begin
            w_status = STATUS_OK;
        end
    end

    // Next ring state for an accepted item
    always_comb begin
        n_head     = r_head;
        n_free_cnt = r_free_cnt;
        n_wmark    = r_wmark;
        if (w_accept && w_pop_ok) begin
            n_head     = (r_head == LAST_POS) ? '0 : r_head + 1'b1;
            n_free_cnt = r_free_cnt - 1'b1;
        end
        if (w_accept && w_push_ok) begin
            n_free_cnt = r_free_cnt + 1'b1;
            if (r_wmark != MAX_CNT) begin
                n_wmark = r_wmark + 1'b1;
            end
        end
    end

    // Free ring storage
    fbfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_push_ok),
        .i_waddr (w_tail_pos),
        .i_wdata (IDX_W'(i_in_data.free_index)),
        .i_re    (w_accept && w_pop_ok),
        .i_raddr (r_head),
        .o_rdata (w_ram_rdata)
    );

    // Control state: config rebuild, divide, run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_eff_size  <= SIZE_RESET;
            r_blk_cnt   <= CNT_W'(RST_CNT);
            r_free_cnt  <= CNT_W'(RST_CNT);
            r_head      <= '0;
            r_wmark     <= '0;
            r_step      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_state    <= ST_DIV;
                r_eff_size <= w_cfg_size;
                r_blk_cnt  <= '0;
                r_free_cnt <= '0;
                r_head     <= '0;
                r_wmark    <= '0;
                r_step     <= LAST_STEP;
            end else if (r_state == ST_DIV) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_state    <= ST_RUN;
                    r_blk_cnt  <= w_quo_cap;
                    r_free_cnt <= w_quo_cap;
                end
            end else begin
                r_head     <= n_head;
                r_free_cnt <= n_free_cnt;
                r_wmark    <= n_wmark;
            end
            r_s1_valid  <= w_accept || (r_s1_valid && !w_s1_move);
            r_out_valid <= w_s1_move || (r_out_valid && i_out_stall);
        end
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Stage one: remember what the RAM read belongs to
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pop    <= w_pop_ok;
            r_s1_hit    <= w_head_hit;
            r_s1_pos    <= r_head;
            r_s1_status <= w_status;
        end
    end

    // Pick the popped index: stored entry, or its own slot if never written
    always_comb begin
        if (!r_s1_pop) begin
            w_sel_index = '0;
        end else if (r_s1_hit) begin
            w_sel_index = w_ram_rdata;
        end else begin
            w_sel_index = r_s1_pos;
        end
        w_prod = PROD_W'(w_sel_index) * PROD_W'(r_eff_size);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data.block_index  <= INDEX_W'(w_sel_index);
            r_out_data.block_offset <= OFFSET_W'(w_prod);
            r_out_data.status       <= r_s1_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    `ASSERT_ALWAYS(a_free_le_blocks, i_clk, i_rst_n, r_free_cnt <= r_blk_cnt)
    `ASSERT_ALWAYS(a_no_accept_in_div, i_clk, i_rst_n, !(w_accept && (r_state == ST_DIV)))
    `ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && r_out_valid && i_out_stall, r_s1_valid)

endmodule

/* verif/fixed_block_free_list_top_tb.sv */
// Testbench for fixed_block_free_list_top: alloc/free items against a free-ring predictor.
// Depends on fbfl_pkg and the fixed_block_free_list_top RTL; stands alone otherwise.
`timescale 1ns / 1ps

module fixed_block_free_list_top_tb;
    import fbfl_pkg::*;

    localparam int POOL_PAGE_BYTES = 4096;
    localparam int POOL_PAGES      = 5;
    localparam int POOL_MAX_BLOCKS = 4096;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 6;
    localparam int MAX_PRINTED     = 20;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    t_req              in_data     = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    t_rsp              out_data;
    logic              cfg_we      = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata   = '0;

    fixed_block_free_list_top #(
        .PAGE_BYTES (POOL_PAGE_BYTES),
        .PAGES      (POOL_PAGES),
        .MAX_BLOCKS (POOL_MAX_BLOCKS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Free-ring predictor state
    logic [SIZE_W-1:0]  pool_size_reg;
    logic [INDEX_W-1:0] pool_ring [0:POOL_MAX_BLOCKS-1];
    logic [INDEX_W-1:0] pool_head;
    logic [SIZE_W-1:0]  pool_free_cnt;
    logic [SIZE_W-1:0]  pool_blk_cnt;

    // Items waiting to be driven, and results still due from the block
    t_req req_backlog [$];
    t_rsp due_rsps [$];

    bit req_taken = 1'b0;
    bit in_hold   = 1'b0;
    int tx_idle_pct = 33;
    int rx_idle_pct = 33;
    bit rx_hold_go  = 1'b0;
    int rx_hold_left = 0;

    int n_errors  = 0;
    int n_items   = 0;
    int n_checked = 0;
    int n_cfg     = 0;
    int n_empty   = 0;
    int n_reject  = 0;
    int cycles    = 0;

    function automatic logic [SIZE_W-1:0] eff_block_size();
        if (pool_size_reg < SIZE_MIN) return SIZE_MIN;
        if (pool_size_reg > SIZE_MAX) return SIZE_MAX;
        return pool_size_reg;
    endfunction

    // Rebuild the free list in order for a new block size
    task automatic pool_rebuild(input logic [SIZE_W-1:0] size_val);
        int n;
        pool_size_reg = size_val;
        n = (POOL_PAGE_BYTES * POOL_PAGES - 1) / int'(eff_block_size());
        if (n > POOL_MAX_BLOCKS) n = POOL_MAX_BLOCKS;
        for (int i = 0; i < POOL_MAX_BLOCKS; i++) pool_ring[i] = i[INDEX_W-1:0];
        pool_blk_cnt  = n[SIZE_W-1:0];
        pool_free_cnt = n[SIZE_W-1:0];
        pool_head     = '0;
    endtask

    // Pop or push the ring for one item and return the result it gives
    function automatic t_rsp pool_step(input t_req req);
        t_rsp             rsp;
        logic [31:0]      prod;
        logic [INDEX_W-1:0] tail;
        rsp = '0;
        rsp.status = STATUS_OK;
        if (req.cmd == CMD_ALLOC) begin
            if (pool_free_cnt == 0) begin
                rsp.status = STATUS_EMPTY;
            end else begin
                rsp.block_index  = pool_ring[pool_head];
                prod             = 32'(pool_ring[pool_head]) * 32'(eff_block_size());
                rsp.block_offset = prod[OFFSET_W-1:0];
                pool_head        = pool_head + 1'b1;
                pool_free_cnt    = pool_free_cnt - 1'b1;
            end
        end else begin
            if (13'(req.free_index) >= pool_blk_cnt || pool_free_cnt >= pool_blk_cnt) begin
                rsp.status = STATUS_REJECT;
            end else begin
                tail            = pool_head + pool_free_cnt[INDEX_W-1:0];
                pool_ring[tail] = req.free_index;
                pool_free_cnt   = pool_free_cnt + 1'b1;
            end
        end
        return rsp;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (n_errors < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_errors++;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Monitor: track config writes, predict accepted items, check results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pool_rebuild(SIZE_RESET);
        end else begin
            if (out_valid && !out_stall) begin
                if (due_rsps.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing due: %p", out_data));
                end else begin
                    t_rsp want;
                    want = due_rsps.pop_front();
                    if (out_data.block_index !== want.block_index)
                        flag_mismatch($sformatf("block_index got %0d want %0d",
                            out_data.block_index, want.block_index));
                    if (out_data.block_offset !== want.block_offset)
                        flag_mismatch($sformatf("block_offset got %0d want %0d",
                            out_data.block_offset, want.block_offset));
                    if (out_data.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                            out_data.status, want.status));
                    if (want.status == STATUS_EMPTY) n_empty++;
                    if (want.status == STATUS_REJECT) n_reject++;
                    n_checked++;
                end
            end
            if (cfg_we) pool_rebuild(cfg_wdata);
            if (in_valid && !in_stall) begin
                due_rsps.push_back(pool_step(in_data));
                req_taken = 1'b1;
                n_items++;
            end
        end
    end

    // Driver: hold an item until it is taken, idle at random between items
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (req_taken) begin
                void'(req_backlog.pop_front());
                req_taken = 1'b0;
                in_hold   = 1'b0;
            end
            if (!in_hold && req_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                in_hold = 1'b1;
                in_data <= req_backlog[0];
            end
            in_valid <= in_hold;
        end
    end

    // Receiver: random stall, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (rx_hold_go) begin
                rx_hold_go   = 1'b0;
                rx_hold_left = HOLD_OFF_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    function automatic t_req make_req(input logic cmd, input logic [INDEX_W-1:0] idx);
        t_req r;
        r.cmd        = cmd;
        r.free_index = idx;
        return r;
    endfunction

    task automatic push_alloc();
        req_backlog.push_back(make_req(CMD_ALLOC, INDEX_W'($urandom)));
    endtask

    task automatic push_free(input int idx);
        req_backlog.push_back(make_req(CMD_FREE, idx[INDEX_W-1:0]));
    endtask

    // Wait until every item is taken and every result has come back
    task automatic wait_idle();
        while (req_backlog.size() != 0 || in_hold || due_rsps.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_block_size(input logic [SIZE_W-1:0] size_val);
        wait_idle();
        cfg_wdata = size_val;
        cfg_we    = 1'b1;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        n_cfg++;
    endtask

    // Bursts of allocs and in-range frees, with stray and out-of-range frees
    task automatic run_random_phase(input int n_req);
        int made;
        int kind;
        int burst;
        int lim;
        made = 0;
        lim  = int'(pool_blk_cnt);
        while (made < n_req) begin
            kind  = $urandom_range(99);
            burst = $urandom_range(1, (lim + 2 > 40) ? 40 : lim + 2);
            if (kind < 40) begin
                repeat (burst) push_alloc();
            end else if (kind < 80) begin
                repeat (burst) push_free($urandom_range(lim - 1));
            end else if (kind < 90) begin
                burst = 1;
                push_free($urandom_range(POOL_MAX_BLOCKS - 1));
            end else begin
                burst = 1;
                push_free($urandom_range(POOL_MAX_BLOCKS - 1, lim));
            end
            made += burst;
        end
    endtask

    // Stimulus sequence
    initial begin
        logic [SIZE_W-1:0] sizes [9];
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default size: allocs, frees at and past the last index, free when full
        push_alloc();
        push_alloc();
        push_free(POOL_MAX_BLOCKS - 1);
        push_free(318);
        push_free(319);
        push_free(0);
        push_free(5);
        push_alloc();
        wait_idle();

        // Largest size: drain to empty, double free, free when full
        write_block_size(SIZE_MAX);
        repeat (5) push_alloc();
        push_free(3);
        push_free(3);
        push_free(0);
        push_free(1);
        push_free(2);
        repeat (5) push_alloc();
        push_free(4);

        // Size below the minimum, then above the maximum
        write_block_size(13'd0);
        push_alloc();
        push_free(2558);
        push_free(2559);
        write_block_size(13'h1FFF);
        push_alloc();
        push_free(0);

        sizes = '{13'd4096, 13'd8, 13'd2048, 13'd8191, 13'd1000,
                  13'd3000, 13'd0, 13'd600, 13'd4095};
        sizes[4] = 13'($urandom_range(8, 4096));
        sizes[8] = 13'($urandom);

        foreach (sizes[p]) begin
            write_block_size(sizes[p]);
            // Stall the output long enough to back the block up
            if (p == 2) rx_hold_go = 1'b1;
            // One stretch with no idling on either side
            if (p == 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 33;
                rx_idle_pct = 33;
            end
            run_random_phase((sizes[p] < 13'd64) ? 60 : 150);
        end
        wait_idle();

        $display("Covered %0d items (%0d results checked, %0d empty, %0d rejected)",
            n_items, n_checked, n_empty, n_reject);
        $display("over %0d block size writes, including sizes out of range.", n_cfg);
        if (n_errors == 0 && due_rsps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* fixed_block_free_list_top.f */
+incdir+design
design/fbfl_pkg.sv
design/fbfl_ram.sv
design/fixed_block_free_list_top.sv
verif/fixed_block_free_list_top_tb.sv
